FILE: sv/quadratic_lowest_root_in_range_top_assert.svh
// assertion macros shared by the rtl files
`ifndef QUADRATIC_LOWEST_ROOT_IN_RANGE_TOP_ASSERT_SVH
`define QUADRATIC_LOWEST_ROOT_IN_RANGE_TOP_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define QLR_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qlr check failed");

// next-cycle implication
`define QLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qlr check failed");

`endif

FILE: sv/qlr_pkg.sv
`default_nettype none
package qlr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int W      = DATA_WIDTH;
    localparam int LIM_W  = W - 1;
    localparam int PROD_W = 2 * W;
    localparam int ROOT_W = W + 1;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 3;
    localparam int NVAL_W = W + 3;
    localparam int MAG_W  = W + 2;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int DEN_W  = W + 1;
    localparam int DREM_W = DEN_W + 1;

    typedef struct packed {
        logic             valid;
        logic             noroot;
        logic             aneg;
        logic             bneg;
        logic [W-1:0]     am;
        logic [W-1:0]     bm;
        logic [LIM_W-1:0] limit;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [SQ_W-1:0]   dsh;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic             valid;
        logic             noroot;
        logic             aneg;
        logic [LIM_W-1:0] limit;
        logic [DEN_W-1:0] den;
    } dside_t;

    typedef struct packed {
        logic              neg;
        logic [NUM_W-1:0]  num;
        logic [DREM_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
    } dlane_t;

    typedef struct packed {
        dside_t          side;
        dlane_t [1:0]    lane;
    } dv_t;

endpackage
`default_nettype wire

FILE: sv/qlr_front.sv
`default_nettype none
module qlr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [qlr_pkg::W-1:0]         coef_a,
    input  wire logic [qlr_pkg::W-1:0]         coef_b,
    input  wire logic [qlr_pkg::W-1:0]         coef_c,
    input  wire logic [qlr_pkg::LIM_W-1:0]     upper_limit,
    output qlr_pkg::sq_t                       out_q
);

    qlr_pkg::side_t                    a_side_reg, a_side_next;
    logic [qlr_pkg::PROD_W-1:0]        bb_reg, bb_next;
    logic [qlr_pkg::PROD_W-1:0]        acp_reg, acp_next;
    logic                              same_reg, same_next;
    qlr_pkg::sq_t                      out_reg, out_next;
    logic [qlr_pkg::W-1:0]             cm;
    logic                              cneg;
    logic [qlr_pkg::SQ_W-1:0]          bb_x, ac4_x;
    logic                              ac_big;

    always_comb begin
        cneg = coef_c[qlr_pkg::W-1];
        cm   = cneg ? (~coef_c + 1'b1) : coef_c;
        a_side_next.valid  = in_valid;
        a_side_next.aneg   = coef_a[qlr_pkg::W-1];
        a_side_next.bneg   = coef_b[qlr_pkg::W-1];
        a_side_next.am     = coef_a[qlr_pkg::W-1] ? (~coef_a + 1'b1) : coef_a;
        a_side_next.bm     = coef_b[qlr_pkg::W-1] ? (~coef_b + 1'b1) : coef_b;
        a_side_next.limit  = upper_limit;
        a_side_next.noroot = (a_side_next.am == '0);
        same_next = (a_side_next.aneg == cneg) || (cm == '0);
        bb_next   = a_side_next.bm * a_side_next.bm;
        acp_next  = a_side_next.am * cm;
    end

    always_comb begin
        bb_x   = qlr_pkg::SQ_W'(bb_reg);
        ac4_x  = {acp_reg, 2'b00};
        ac_big = same_reg && (ac4_x > bb_x);
        out_next.side        = a_side_reg;
        out_next.side.noroot = a_side_reg.noroot || ac_big;
        out_next.dsh         = same_reg ? (bb_x - ac4_x) : (bb_x + ac4_x);
        out_next.rem         = '0;
        out_next.root        = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_side_reg.valid <= 1'b0;
            out_reg.side.valid <= 1'b0;
        end else if (en) begin
            a_side_reg <= a_side_next;
            bb_reg     <= bb_next;
            acp_reg    <= acp_next;
            same_reg   <= same_next;
            out_reg    <= out_next;
        end
    end

    assign out_q = out_reg;

endmodule
`default_nettype wire

FILE: sv/qlr_sqrt_cell.sv
`default_nettype none
module qlr_sqrt_cell (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire qlr_pkg::sq_t in_q,
    output qlr_pkg::sq_t out_q
);

    `include "quadratic_lowest_root_in_range_top_assert.svh"

    qlr_pkg::sq_t                  q_reg, q_next;
    logic [qlr_pkg::SREM_W-1:0]    cur, trial;
    logic                          ge;

    // one root bit per cell, two discriminant bits shifted in
    always_comb begin
        cur   = {in_q.rem[qlr_pkg::SREM_W-3:0], in_q.dsh[qlr_pkg::SQ_W-1 -: 2]};
        trial = qlr_pkg::SREM_W'({in_q.root, 2'b01});
        ge    = (cur >= trial);
        q_next.side = in_q.side;
        q_next.dsh  = {in_q.dsh[qlr_pkg::SQ_W-3:0], 2'b00};
        q_next.rem  = ge ? (cur - trial) : cur;
        q_next.root = {in_q.root[qlr_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.side.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign out_q = q_reg;

    `QLR_ASSERT_HOLDS(a_sqrt_rem_bound, q_reg.side.valid,
        q_reg.rem <= qlr_pkg::SREM_W'({q_reg.root, 1'b0}))

endmodule
`default_nettype wire

FILE: sv/qlr_div_cell.sv
`default_nettype none
module qlr_div_cell (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire qlr_pkg::dv_t in_q,
    output qlr_pkg::dv_t out_q
);

    `include "quadratic_lowest_root_in_range_top_assert.svh"

    qlr_pkg::dv_t                  q_reg, q_next;
    logic [qlr_pkg::DREM_W-1:0]    cur [2];
    logic [qlr_pkg::DREM_W-1:0]    den_x;
    logic                          ge [2];

    // one quotient bit per cell for both roots
    always_comb begin
        den_x       = qlr_pkg::DREM_W'(in_q.side.den);
        q_next.side = in_q.side;
        for (int i = 0; i < 2; i++) begin
            cur[i] = {in_q.lane[i].rem[qlr_pkg::DREM_W-2:0],
                      in_q.lane[i].num[qlr_pkg::NUM_W-1]};
            ge[i]  = (cur[i] >= den_x);
            q_next.lane[i].neg = in_q.lane[i].neg;
            q_next.lane[i].num = {in_q.lane[i].num[qlr_pkg::NUM_W-2:0], 1'b0};
            q_next.lane[i].rem = ge[i] ? (cur[i] - den_x) : cur[i];
            q_next.lane[i].quo = {in_q.lane[i].quo[qlr_pkg::NUM_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.side.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign out_q = q_reg;

    `QLR_ASSERT_HOLDS(a_div_rem_bound, q_reg.side.valid && !q_reg.side.noroot,
        q_reg.lane[0].rem < qlr_pkg::DREM_W'(q_reg.side.den))
    `QLR_ASSERT_NEXT(a_div_hold, !en, $stable(q_reg.lane))

endmodule
`default_nettype wire

FILE: sv/quadratic_lowest_root_in_range_top.sv
// lowest root of a*x^2+b*x+c lying in zero to limit; coefficients signed q16.16, root and limit unsigned q15.16
//
// slave side: one word per query, s_tdata holds coef_a, coef_b, coef_c,
// upper_limit from the lowest bit up. master side: one word per query,
// m_tdata holds found and root_value; root_value is zero when nothing found.
// results leave in the order the queries came in.
//
// a new word is taken every cycle that s_tready is high. from accept to
// m_tvalid a query passes the multiplier and discriminant registers, 33
// square root cells (one root bit each), the register that forms both
// numerators, 50 divider cells (one quotient bit each, both roots side by
// side) and the output register.
//
// when the receiver holds m_tready low with a word waiting, the whole
// chain freezes and s_tready drops; nothing is lost. reset (aresetn low,
// synchronous) clears every valid bit in the chain and m_tvalid.
`default_nettype none
module quadratic_lowest_root_in_range_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // coef_a, coef_b, coef_c, upper_limit, zero pad
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // found, root_value
    output logic [31:0]       m_tdata
);

    `include "quadratic_lowest_root_in_range_top_assert.svh"

    localparam int W = qlr_pkg::W;

    logic                       en;
    qlr_pkg::sq_t               sq_chain [qlr_pkg::ROOT_W+1];
    qlr_pkg::dv_t               dv_chain [qlr_pkg::NUM_W+1];
    qlr_pkg::dv_t               mid_reg, mid_next;
    logic [qlr_pkg::NVAL_W-1:0] nb, s_x;
    logic [qlr_pkg::NVAL_W-1:0] nv [2];
    logic [qlr_pkg::NVAL_W-1:0] nmag [2];
    qlr_pkg::dv_t               last;
    logic                       ok [2];
    logic [qlr_pkg::LIM_W-1:0]  val [2];
    logic                       found_next;
    logic [qlr_pkg::LIM_W-1:0]  root_next;
    logic                       m_tvalid_reg;
    logic                       found_reg;
    logic [qlr_pkg::LIM_W-1:0]  root_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    qlr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .coef_a      (s_tdata[W-1:0]),
        .coef_b      (s_tdata[2*W-1:W]),
        .coef_c      (s_tdata[3*W-1:2*W]),
        .upper_limit (s_tdata[4*W-2:3*W]),
        .out_q       (sq_chain[0])
    );

    for (genvar k = 0; k < qlr_pkg::ROOT_W; k++) begin : g_sqrt
        qlr_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_q    (sq_chain[k]),
            .out_q   (sq_chain[k+1])
        );
    end

    // numerators -b -/+ s as sign and magnitude, denominator 2|a| with the sign of a kept apart
    always_comb begin
        nb = sq_chain[qlr_pkg::ROOT_W].side.bneg
            ? qlr_pkg::NVAL_W'(sq_chain[qlr_pkg::ROOT_W].side.bm)
            : -qlr_pkg::NVAL_W'(sq_chain[qlr_pkg::ROOT_W].side.bm);
        s_x   = qlr_pkg::NVAL_W'(sq_chain[qlr_pkg::ROOT_W].root);
        nv[0] = nb - s_x;
        nv[1] = nb + s_x;
        mid_next.side.valid  = sq_chain[qlr_pkg::ROOT_W].side.valid;
        mid_next.side.noroot = sq_chain[qlr_pkg::ROOT_W].side.noroot;
        mid_next.side.aneg   = sq_chain[qlr_pkg::ROOT_W].side.aneg;
        mid_next.side.limit  = sq_chain[qlr_pkg::ROOT_W].side.limit;
        mid_next.side.den    = {sq_chain[qlr_pkg::ROOT_W].side.am, 1'b0};
        for (int i = 0; i < 2; i++) begin
            nmag[i] = nv[i][qlr_pkg::NVAL_W-1] ? -nv[i] : nv[i];
            mid_next.lane[i].neg = nv[i][qlr_pkg::NVAL_W-1];
            mid_next.lane[i].num = {nmag[i][qlr_pkg::MAG_W-1:0],
                                    qlr_pkg::FRAC_BITS'(0)};
            mid_next.lane[i].rem = '0;
            mid_next.lane[i].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.side.valid <= 1'b0;
        end else if (en) begin
            mid_reg <= mid_next;
        end
    end

    assign dv_chain[0] = mid_reg;

    for (genvar k = 0; k < qlr_pkg::NUM_W; k++) begin : g_div
        qlr_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_q    (dv_chain[k]),
            .out_q   (dv_chain[k+1])
        );
    end

    // a quotient that truncates to zero counts as root zero
    always_comb begin
        last = dv_chain[qlr_pkg::NUM_W];
        for (int i = 0; i < 2; i++) begin
            val[i] = last.lane[i].quo[qlr_pkg::LIM_W-1:0];
            if (last.lane[i].quo == '0) begin
                ok[i]  = 1'b1;
                val[i] = '0;
            end else if (last.lane[i].neg != last.side.aneg) begin
                ok[i] = 1'b0;
            end else begin
                ok[i] = (last.lane[i].quo <= qlr_pkg::NUM_W'(last.side.limit));
            end
        end
        found_next = !last.side.noroot && (ok[0] || ok[1]);
        if (!found_next) begin
            root_next = '0;
        end else if (ok[0] && ok[1]) begin
            root_next = (val[0] < val[1]) ? val[0] : val[1];
        end else if (ok[0]) begin
            root_next = val[0];
        end else begin
            root_next = val[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= last.side.valid;
            found_reg    <= found_next;
            root_reg     <= root_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {root_reg, found_reg};

    `QLR_ASSERT_HOLDS(a_root_in_limit, last.side.valid && found_next,
        root_next <= last.side.limit)
    `QLR_ASSERT_HOLDS(a_noroot_not_found, last.side.valid && last.side.noroot, !found_next)
    `QLR_ASSERT_HOLDS(a_stall_blocks_intake, m_tvalid && !m_tready, !s_tready)

endmodule
`default_nettype wire
